FILE: hdl/epoch_seconds_to_date_top_defines.svh
// Assertion macros for the epoch seconds to date converter.
// Included by the top level; no other dependencies.
`ifndef EPOCH_SECONDS_TO_DATE_TOP_DEFINES_SVH
`define EPOCH_SECONDS_TO_DATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is applied.
`define ES2D_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is applied.
`define ES2D_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ES2D_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`define ES2D_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: hdl/es2d_pkg.sv
// Constants and the month table for the epoch seconds to date converter.
// No dependencies; used by epoch_seconds_to_date_top.
package es2d_pkg;

	// Calendar constants.
	localparam int unsigned BaseYear  = 1970;
	localparam int unsigned DaysCycle = 1461;
	localparam int unsigned SecsDay   = 86400;
	localparam int unsigned SecsMin   = 60;
	localparam int unsigned Year2Day  = 730;
	localparam int unsigned Year3Day  = 1096;
	localparam int unsigned Year1Day  = 365;

	// Reciprocal multipliers. Each quotient is exact over the value range
	// that reaches it, since value times the rounding error stays below 2^shift.
	// Days: (seconds >> 7) / 675.
	localparam logic [25:0] DayRecip   = 26'd50903317;
	localparam int unsigned DayShift   = 35;
	// Cycles: days / 1461.
	localparam logic [15:0] CycRecip   = 16'd45934;
	localparam int unsigned CycShift   = 26;
	// Minutes: (seconds of day >> 2) / 15.
	localparam logic [14:0] MinRecip   = 15'd17477;
	localparam int unsigned MinShift   = 18;
	// Hours: (minutes of day >> 2) / 15.
	localparam logic [10:0] HourRecip  = 11'd1093;
	localparam int unsigned HourShift  = 14;

	// Month indexes (0 is January).
	localparam logic [3:0] MonJan = 4'd0;
	localparam logic [3:0] MonMar = 4'd2;
	localparam logic [3:0] MonDec = 4'd11;

	// First day of each month within the year, for a common year or, with leap set, a leap year.
	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic [8:0] base;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd334;
		endcase
		// From March on, a leap year is one day further along.
		if (idx >= MonMar && idx <= MonDec) begin
			base = base + 9'(leap);
		end
		return base;
	endfunction

endpackage

FILE: hdl/epoch_seconds_to_date_top.sv
// Epoch seconds to calendar date and time of day, six-stage pipeline.
// Depends on es2d_pkg and epoch_seconds_to_date_top_defines.svh.
//
//  channel  dir  word                                   handshake
//  s_*      in   epoch seconds, 32 bits                 tvalid/tready
//  m_*      out  year, month, day, hour, minute         tvalid/tready
//
// One word enters per cycle while no stall holds the pipeline; each result appears
// on m_* once it has passed the registered stages s1 to s6. Every stage holds its
// own valid bit, so a bubble anywhere is filled while the output waits. Reset
// clears the valid bits only. A stalled output holds its stage, and each earlier
// stage stalls only when the stage after it is full and stalled.
`include "epoch_seconds_to_date_top_defines.svh"

module epoch_seconds_to_date_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [11:0] year, [15:12] month, [20:16] day_of_month,
	                               // [25:21] hour, [31:26] minute
);

	// Stage valid bits and advance enables.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	// Stage payloads.
	logic [31:0] sec_s1;
	logic [31:0] sec_s2;
	logic [15:0] day_s2;
	logic [16:0] dsec_s3;
	logic [15:0] day_s3;
	logic [5:0]  cyc_s3;
	logic [10:0] yd_s4;
	logic [10:0] mins_s4;
	logic [5:0]  cyc_s4;
	logic [11:0] year_s5;
	logic [8:0]  ydy_s5;
	logic        leap_s5;
	logic [10:0] mins_s5;
	logic [4:0]  hour_s5;
	logic [11:0] year_s6;
	logic [3:0]  month_s6;
	logic [4:0]  dom_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  minute_s6;

	// A stage moves when it is empty or the stage after it moves.
	assign adv_s6   = !vld_s6 || m_tready;
	assign adv_s5   = !vld_s5 || adv_s6;
	assign adv_s4   = !vld_s4 || adv_s5;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign s_tready = adv_s1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= s_tvalid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
		end
	end

	// Stage 2: whole days, as (seconds >> 7) / 675.
	logic [50:0] day_prod;
	assign day_prod = 51'(sec_s1[31:7]) * 51'(es2d_pkg::DayRecip);

	// Stage 3: seconds of day and four-year cycle number.
	logic [31:0] dsec_full;
	logic [31:0] cyc_prod;
	assign dsec_full = sec_s2 - 32'(day_s2) * 32'(es2d_pkg::SecsDay);
	assign cyc_prod  = 32'(day_s2) * 32'(es2d_pkg::CycRecip);

	// Stage 4: day within the cycle and minutes of day.
	logic [15:0] yd_full;
	logic [31:0] mins_prod;
	assign yd_full   = day_s3 - 16'(32'(cyc_s3) * 32'(es2d_pkg::DaysCycle));
	assign mins_prod = 32'(dsec_s3[16:2]) * 32'(es2d_pkg::MinRecip);

	// Stage 5: year within the cycle, and hour of day.
	logic [1:0]  yoff;
	logic [10:0] ydy_full;
	logic        leap;
	logic [31:0] hour_prod;
	always_comb begin
		yoff     = 2'd0;
		ydy_full = yd_s4;
		leap     = 1'b0;
		if (yd_s4 >= 11'(es2d_pkg::Year3Day)) begin
			yoff     = 2'd3;
			ydy_full = yd_s4 - 11'(es2d_pkg::Year3Day);
		end else if (yd_s4 >= 11'(es2d_pkg::Year2Day)) begin
			yoff     = 2'd2;
			ydy_full = yd_s4 - 11'(es2d_pkg::Year2Day);
			leap     = 1'b1;
		end else if (yd_s4 >= 11'(es2d_pkg::Year1Day)) begin
			yoff     = 2'd1;
			ydy_full = yd_s4 - 11'(es2d_pkg::Year1Day);
		end
	end
	assign hour_prod = 32'(mins_s4[10:2]) * 32'(es2d_pkg::HourRecip);

	// Stage 6: month by threshold compare, day of month and minute.
	logic [3:0]  mon;
	logic [8:0]  mstart;
	logic [10:0] minute_full;
	always_comb begin
		mon = es2d_pkg::MonJan;
		for (int m = 1; m < 12; m++) begin
			if (ydy_s5 >= es2d_pkg::month_start(4'(m), leap_s5)) begin
				mon = 4'(m);
			end
		end
	end
	assign mstart      = es2d_pkg::month_start(mon, leap_s5);
	assign minute_full = mins_s5 - 11'(16'(hour_s5) * 16'(es2d_pkg::SecsMin));

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sec_s1 <= s_tdata;
		end
		if (adv_s2) begin
			sec_s2 <= sec_s1;
			day_s2 <= day_prod[es2d_pkg::DayShift +: 16];
		end
		if (adv_s3) begin
			dsec_s3 <= dsec_full[16:0];
			day_s3  <= day_s2;
			cyc_s3  <= cyc_prod[es2d_pkg::CycShift +: 6];
		end
		if (adv_s4) begin
			yd_s4   <= yd_full[10:0];
			mins_s4 <= mins_prod[es2d_pkg::MinShift +: 11];
			cyc_s4  <= cyc_s3;
		end
		if (adv_s5) begin
			year_s5 <= 12'(es2d_pkg::BaseYear) + {4'd0, cyc_s4, 2'b00} + 12'(yoff);
			ydy_s5  <= ydy_full[8:0];
			leap_s5 <= leap;
			mins_s5 <= mins_s4;
			hour_s5 <= hour_prod[es2d_pkg::HourShift +: 5];
		end
		if (adv_s6) begin
			year_s6   <= year_s5;
			month_s6  <= mon + 4'd1;
			dom_s6    <= 5'(ydy_s5 - mstart + 9'd1);
			hour_s6   <= hour_s5;
			minute_s6 <= minute_full[5:0];
		end
	end

	// Output word.
	assign m_tvalid = vld_s6;
	assign m_tdata  = {minute_s6, hour_s6, dom_s6, month_s6, year_s6};

	// Checks on the divide steps, the result fields and the stall chain.
	`ES2D_ASSERT_IMPL(a_dsec_range, clk, arst_n, vld_s3, dsec_s3 < 17'd86400, "bad seconds of day")
	`ES2D_ASSERT_IMPL(a_yd_range, clk, arst_n, vld_s4, yd_s4 < 11'd1461, "bad day of cycle")
	`ES2D_ASSERT_IMPL(a_date, clk, arst_n, vld_s6, month_s6 - 4'd1 < 4'd12 && dom_s6 != 5'd0, "bad date")
	`ES2D_ASSERT_IMPL(a_time, clk, arst_n, vld_s6, hour_s6 < 5'd24 && minute_s6 < 6'd60, "bad time")
	`ES2D_ASSERT_NEXT(a_stall_hold, clk, arst_n, vld_s5 && !adv_s5, vld_s5, "stall lost word")

endmodule
